>>> rtl/drt_pkg.sv
// shared types, constants and span tables for the difficulty retarget pipeline
package drt_pkg;

  localparam int TARGET_BITS = 256;
  localparam int DIGIT_W     = 16;
  localparam int DIGITS      = TARGET_BITS / DIGIT_W;
  localparam int REM_W       = 15;
  localparam int X_W         = REM_W + DIGIT_W;
  localparam int PROD_W      = 62;
  localparam int LIMBS       = TARGET_BITS / 32;
  localparam int LATENCY     = 41;

  // register indexes of the configuration port
  localparam logic [7:0] REG_LIMIT0 = 8'd0;
  localparam logic [7:0] REG_LIMIT1 = 8'd1;
  localparam logic [7:0] REG_LIMIT2 = 8'd2;
  localparam logic [7:0] REG_LIMIT3 = 8'd3;

  localparam logic [63:0] LIMIT0_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT1_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT2_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT3_RST = 64'h0000_0FFF_FFFF_FFFF;

  localparam logic [30:0] H_FAST = 31'd7770000;
  localparam logic [30:0] H_SLOW = 31'd7331700;
  localparam logic [30:0] H_HIST = 31'd15000;

  // largest timespan that still matters once divided and clamped
  localparam logic [18:0] A_CAP      = 19'd432005;
  localparam logic [19:0] RECIP6     = 20'd699051;
  localparam int          RECIP6_SH  = 22;

  typedef enum logic [1:0] {
    SPAN_360,
    SPAN_18000,
    SPAN_900
  } span_t;

  typedef struct packed {
    logic  valid;
    span_t span;
  } drt_ctl_t;

  function automatic logic [REM_W-1:0] span_val(span_t s);
    case (s)
      SPAN_18000: span_val = 15'd18000;
      SPAN_900:   span_val = 15'd900;
      default:    span_val = 15'd360;
    endcase
  endfunction

  function automatic logic [16:0] span_lo(span_t s);
    case (s)
      SPAN_18000: span_lo = 17'd4500;
      SPAN_900:   span_lo = 17'd225;
      default:    span_lo = 17'd90;
    endcase
  endfunction

  function automatic logic [16:0] span_hi(span_t s);
    case (s)
      SPAN_18000: span_hi = 17'd72000;
      SPAN_900:   span_hi = 17'd3600;
      default:    span_hi = 17'd1440;
    endcase
  endfunction

  // ceil(2^k / span), exact for every partial dividend below span * 2^16
  function automatic logic [30:0] span_recip(span_t s);
    case (s)
      SPAN_18000: span_recip = 31'd1954687339;
      SPAN_900:   span_recip = 31'd76354975;
      default:    span_recip = 31'd47721859;
    endcase
  endfunction

  function automatic logic [5:0] span_shift(span_t s);
    case (s)
      SPAN_18000: span_shift = 6'd45;
      SPAN_900:   span_shift = 6'd36;
      default:    span_shift = 6'd34;
    endcase
  endfunction

endpackage

>>> rtl/difficulty_retarget.sv
// next compact target from one retarget window, fully pipelined
//
// channel   direction  handshake                   payload
// item in   in         start, busy                 last_height last_time first_time last_bits
// result    out        done (one-cycle strobe)     next_bits
// config    in         cfg_valid, cfg_ready        cfg_index cfg_data
//
// one item per cycle outside reset; results leave in the order their items are taken
// most of the pipeline is the long division: two stages per 16-bit digit, 16 digits
// rst clears the stage valid bits and restores the limit words
// busy is high only during reset; cfg_ready is always high
module difficulty_retarget (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] last_height,
  input  logic [31:0] last_time,
  input  logic [31:0] first_time,
  input  logic [31:0] last_bits,
  output logic        done,
  output logic [31:0] next_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import drt_pkg::*;

  logic [63:0] limit0, limit1, limit2, limit3;
  logic [TARGET_BITS-1:0] lim;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign lim       = {limit3, limit2, limit1, limit0};

  always_ff @(posedge clk) begin
    if (rst) begin
      limit0 <= LIMIT0_RST;
      limit1 <= LIMIT1_RST;
      limit2 <= LIMIT2_RST;
      limit3 <= LIMIT3_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIMIT0: limit0 <= cfg_data;
        REG_LIMIT1: limit1 <= cfg_data;
        REG_LIMIT2: limit2 <= cfg_data;
        REG_LIMIT3: limit3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: decode compact target, pick span, raw timespan
  logic                   take;
  logic [7:0]             expo;
  logic [TARGET_BITS-1:0] mant;
  logic [TARGET_BITS-1:0] dec;
  span_t                  span_in;
  logic                   hist_in;
  logic [32:0]            diff;
  logic [18:0]            a_in;

  assign take = start && !busy;

  always_comb begin
    expo = last_bits[31:24];
    mant = TARGET_BITS'(last_bits[22:0]);
    if (expo <= 8'd3) begin
      dec = mant >> {2'(8'd3 - expo), 3'b000};
    end else begin
      dec = mant << {8'(expo - 8'd3), 3'b000};
    end
    if (last_height >= H_FAST) begin
      span_in = SPAN_900;
    end else if (last_height >= H_SLOW) begin
      span_in = SPAN_18000;
    end else begin
      span_in = SPAN_360;
    end
    hist_in = last_height > H_HIST;
    diff    = {1'b0, last_time} - {1'b0, first_time};
    // a negative span ends at the low clamp, so zero stands in for it
    if (diff[32]) begin
      a_in = '0;
    end else if (diff[31:0] > 32'(A_CAP)) begin
      a_in = A_CAP;
    end else begin
      a_in = diff[18:0];
    end
  end

  drt_ctl_t               s1_ctl;
  logic                   s1_hist;
  logic [18:0]            s1_a;
  logic [TARGET_BITS-1:0] s1_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= take;
    end
    s1_ctl.span <= span_in;
    s1_hist     <= hist_in;
    s1_a        <= a_in;
    s1_w        <= dec;
  end

  // stage 2: reciprocal multiply for the divide by six
  drt_ctl_t               s2_ctl;
  logic                   s2_hist;
  logic [18:0]            s2_a;
  logic [38:0]            s2_prod6;
  logic [TARGET_BITS-1:0] s2_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else begin
      s2_ctl.valid <= s1_ctl.valid;
    end
    s2_ctl.span <= s1_ctl.span;
    s2_hist     <= s1_hist;
    s2_a        <= s1_a;
    s2_prod6    <= 39'(s1_a) * 39'(RECIP6);
    s2_w        <= s1_w;
  end

  // stage 3: history divide and clamp
  logic [18:0] ad;
  logic [16:0] a_clamp;

  always_comb begin
    if (!s2_hist) begin
      ad = s2_a;
    end else if (s2_ctl.span == SPAN_18000) begin
      ad = 19'(s2_prod6 >> RECIP6_SH);
    end else begin
      ad = s2_a >> 1;
    end
    if (ad < 19'(span_lo(s2_ctl.span))) begin
      a_clamp = span_lo(s2_ctl.span);
    end else if (ad > 19'(span_hi(s2_ctl.span))) begin
      a_clamp = span_hi(s2_ctl.span);
    end else begin
      a_clamp = ad[16:0];
    end
  end

  drt_ctl_t               s3_ctl;
  logic [16:0]            s3_a;
  logic [TARGET_BITS-1:0] s3_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.valid <= 1'b0;
    end else begin
      s3_ctl.valid <= s2_ctl.valid;
    end
    s3_ctl.span <= s2_ctl.span;
    s3_a        <= a_clamp;
    s3_w        <= s2_w;
  end

  // stage 4: one 32x17 partial product per limb
  drt_ctl_t    s4_ctl;
  logic [48:0] s4_p [LIMBS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl.valid <= 1'b0;
    end else begin
      s4_ctl.valid <= s3_ctl.valid;
    end
    s4_ctl.span <= s3_ctl.span;
    for (int i = 0; i < LIMBS; i++) begin
      s4_p[i] <= 49'(s3_w[32*i +: 32]) * 49'(s3_a);
    end
  end

  // stage 5: fold partial products, top carry-out dropped
  logic [TARGET_BITS-1:0] lo_sum;
  logic [TARGET_BITS-1:0] hi_sum;

  always_comb begin
    lo_sum = '0;
    hi_sum = '0;
    for (int i = 0; i < LIMBS; i++) begin
      lo_sum[32*i +: 32] = s4_p[i][31:0];
    end
    for (int i = 0; i < LIMBS - 1; i++) begin
      hi_sum[32*(i+1) +: 32] = 32'(s4_p[i][48:32]);
    end
  end

  drt_ctl_t               s5_ctl;
  logic [TARGET_BITS-1:0] s5_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctl.valid <= 1'b0;
    end else begin
      s5_ctl.valid <= s4_ctl.valid;
    end
    s5_ctl.span <= s4_ctl.span;
    s5_w        <= lo_sum + hi_sum;
  end

  drt_ctl_t               dv_ctl;
  logic [TARGET_BITS-1:0] dv_w;

  drt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (s5_ctl),
    .in_w    (s5_w),
    .out_ctl (dv_ctl),
    .out_w   (dv_w)
  );

  // stage 6: cap at the limit
  logic                   s6_valid;
  logic [TARGET_BITS-1:0] s6_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= dv_ctl.valid;
    end
    s6_w <= (dv_w > lim) ? lim : dv_w;
  end

  // stage 7: byte length of the target
  logic [5:0] size_c;

  always_comb begin
    size_c = '0;
    for (int i = 0; i < TARGET_BITS / 8; i++) begin
      if (s6_w[8*i +: 8] != 8'd0) begin
        size_c = 6'(i + 1);
      end
    end
  end

  logic                   s7_valid;
  logic [5:0]             s7_size;
  logic [TARGET_BITS-1:0] s7_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_size <= size_c;
    s7_w    <= s6_w;
  end

  // stage 8: pull out the three top bytes
  logic [31:0]            low_sh;
  logic [TARGET_BITS-1:0] high_sh;
  logic [23:0]            mant_c;

  always_comb begin
    low_sh  = s7_w[31:0] << {2'(6'd3 - s7_size), 3'b000};
    high_sh = s7_w >> {6'(s7_size - 6'd3), 3'b000};
    if (s7_size <= 6'd3) begin
      mant_c = low_sh[23:0];
    end else begin
      mant_c = high_sh[23:0];
    end
  end

  logic        s8_valid;
  logic [5:0]  s8_size;
  logic [23:0] s8_mant;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= s7_valid;
    end
    s8_size <= s7_size;
    s8_mant <= mant_c;
  end

  // stage 9: keep the sign bit clear
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s8_valid;
    end
    if (s8_mant[23]) begin
      next_bits <= {8'(s8_size + 6'd1), 8'd0, s8_mant[23:8]};
    end else begin
      next_bits <= {8'(s8_size), s8_mant};
    end
  end

endmodule

>>> rtl/drt_div.sv
// pipelined long division of the 256-bit product by the target timespan
module drt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  drt_pkg::drt_ctl_t             in_ctl,
  input  logic [drt_pkg::TARGET_BITS-1:0] in_w,
  output drt_pkg::drt_ctl_t             out_ctl,
  output logic [drt_pkg::TARGET_BITS-1:0] out_w
);
  import drt_pkg::*;

  drt_ctl_t               a_ctl  [DIGITS];
  logic [TARGET_BITS-1:0] a_w    [DIGITS];
  logic [X_W-1:0]         a_x    [DIGITS];
  logic [PROD_W-1:0]      a_prod [DIGITS];
  drt_ctl_t               b_ctl  [DIGITS];
  logic [TARGET_BITS-1:0] b_w    [DIGITS];
  logic [REM_W-1:0]       b_rem  [DIGITS];

  for (genvar g = 0; g < DIGITS; g++) begin : g_digit
    localparam int D = DIGITS - 1 - g;
    drt_ctl_t               src_ctl;
    logic [TARGET_BITS-1:0] src_w;
    logic [REM_W-1:0]       src_rem;
    logic [X_W-1:0]         x;
    logic [DIGIT_W-1:0]     q;
    logic [X_W-1:0]         qt;
    logic [REM_W-1:0]       rem_next;
    logic [TARGET_BITS-1:0] w_next;

    if (g == 0) begin : g_first
      assign src_ctl = in_ctl;
      assign src_w   = in_w;
      assign src_rem = '0;
    end else begin : g_rest
      assign src_ctl = b_ctl[g-1];
      assign src_w   = b_w[g-1];
      assign src_rem = b_rem[g-1];
    end

    assign x = {src_rem, src_w[D*DIGIT_W +: DIGIT_W]};

    // reciprocal multiply for the quotient digit
    always_ff @(posedge clk) begin
      if (rst) begin
        a_ctl[g].valid <= 1'b0;
      end else begin
        a_ctl[g].valid <= src_ctl.valid;
      end
      a_ctl[g].span <= src_ctl.span;
      a_w[g]        <= src_w;
      a_x[g]        <= x;
      a_prod[g]     <= PROD_W'(x) * PROD_W'(span_recip(src_ctl.span));
    end

    always_comb begin
      q        = DIGIT_W'(a_prod[g] >> span_shift(a_ctl[g].span));
      qt       = X_W'(q) * X_W'(span_val(a_ctl[g].span));
      rem_next = REM_W'(a_x[g] - qt);
      w_next   = a_w[g];
      w_next[D*DIGIT_W +: DIGIT_W] = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        b_ctl[g].valid <= 1'b0;
      end else begin
        b_ctl[g].valid <= a_ctl[g].valid;
      end
      b_ctl[g].span <= a_ctl[g].span;
      b_w[g]        <= w_next;
      b_rem[g]      <= rem_next;
    end
  end

  assign out_ctl = b_ctl[DIGITS-1];
  assign out_w   = b_w[DIGITS-1];

endmodule

>>> rtl/drt_chk.sv
// port-level checks on the difficulty retarget block, bound to the top level
module drt_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] next_bits
);
  import drt_pkg::*;

  // every item taken gives its result a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after item");

  // no result without an item taken that long before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without item");

  a_sign_clear: assert property (@(posedge clk) disable iff (rst)
    done |-> !next_bits[23])
    else $error("sign bit set in result");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (next_bits[31:24] <= 8'd33))
    else $error("exponent out of range");

endmodule

bind difficulty_retarget drt_chk u_drt_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .next_bits (next_bits)
);
